/* rtl/asm_tok_pkg.sv */
`timescale 1ns / 1ps
// types, constants and character-class helpers for the assembler tokenizer
// no dependencies; used by assembler_tokenizer_core

package asm_tok_pkg;

    // width of the internal byte offset counter
    localparam int POSITION_BITS = 16;
    // width of reported offsets and lengths
    localparam int FIELD_BITS = 16;
    // result queue depth and its index and count widths
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    typedef logic [POSITION_BITS-1:0] pos_t;

    // lexer modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_MNEM    = 3'd1,
        MODE_FLAG    = 3'd2,
        MODE_NUM     = 3'd3,
        MODE_COMMENT = 3'd4
    } mode_t;

    // token kinds as reported
    typedef enum logic [2:0] {
        KIND_END     = 3'd0,
        KIND_MNEM    = 3'd1,
        KIND_FLAG    = 3'd2,
        KIND_NUM     = 3'd3,
        KIND_UNKNOWN = 3'd4
    } kind_t;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SEMI  = 8'h3b;

    // one queued result item
    typedef struct packed {
        kind_t                 kind;
        logic [FIELD_BITS-1:0] start;
        logic [FIELD_BITS-1:0] length;
        logic                  last;
    } token_t;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_separator(input logic [7:0] c);
        return c inside {CH_SPACE, CH_LF, CH_TAB, CH_CR, CH_COMMA};
    endfunction

    // saturating increment of a byte offset
    function automatic pos_t pos_inc(input pos_t p);
        return (&p) ? p : p + pos_t'(1);
    endfunction

endpackage

/* rtl/assembler_tokenizer_core.sv */
`timescale 1ns / 1ps
// assembler tokenizer: text bytes in, tokens (kind, start, length) out
// depends on asm_tok_pkg

// Takes one text byte per cycle and reports mnemonic, flag, number, unknown
// and end tokens. Each accepted byte updates the lexer state in the cycle it
// is taken and writes zero, one or two result items into a four-entry result
// queue; the output side drains one item per cycle while out_stall is low.
// The input is stalled while fewer than two queue entries are free, so a
// byte is taken every cycle as long as the output is not stalled and bytes
// give at most one token on average. Results are registered in the queue
// and read from its head. last_of_run marks the final item caused by a
// byte. Offsets count from the first byte after reset or after an end
// token and stop at their top value.

module assembler_tokenizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);

    // lexer state
    asm_tok_pkg::mode_t mode_reg, mode_next;
    asm_tok_pkg::pos_t  begin_reg, begin_next;
    asm_tok_pkg::pos_t  pos_reg, pos_next;

    // result queue
    asm_tok_pkg::token_t queue_reg [asm_tok_pkg::QUEUE_DEPTH];
    logic [asm_tok_pkg::QUEUE_IDX_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [asm_tok_pkg::QUEUE_IDX_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [asm_tok_pkg::QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic [asm_tok_pkg::QUEUE_IDX_BITS-1:0] wr_ptr_plus1;

    logic                accept;
    logic                pop;
    logic                close_v;
    logic                second_v;
    logic                between;
    asm_tok_pkg::token_t close_tok;
    asm_tok_pkg::token_t second_tok;
    asm_tok_pkg::token_t entry0;
    asm_tok_pkg::token_t entry1;
    logic [1:0]          n_res;
    asm_tok_pkg::pos_t   tok_len;

    // handshakes
    assign in_stall = (count_reg > asm_tok_pkg::QUEUE_CNT_BITS'(asm_tok_pkg::QUEUE_DEPTH - 2));
    assign accept   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;

    assign tok_len = (pos_reg >= begin_reg) ? (pos_reg - begin_reg) : '0;

    // lexer step: state update and the results of this byte
    always_comb
    begin
        mode_next  = mode_reg;
        begin_next = begin_reg;
        pos_next   = asm_tok_pkg::pos_inc(pos_reg);
        between    = 1'b0;
        close_v    = 1'b0;
        second_v   = 1'b0;
        close_tok  = '{kind: asm_tok_pkg::KIND_END,
                       start: asm_tok_pkg::FIELD_BITS'(begin_reg),
                       length: asm_tok_pkg::FIELD_BITS'(tok_len),
                       last: 1'b0};
        second_tok = '{kind: asm_tok_pkg::KIND_END,
                       start: asm_tok_pkg::FIELD_BITS'(pos_reg),
                       length: asm_tok_pkg::FIELD_BITS'(1),
                       last: 1'b0};

        // close or continue the open token
        case (mode_reg)
            asm_tok_pkg::MODE_MNEM,
            asm_tok_pkg::MODE_FLAG:
            begin
                if (!(asm_tok_pkg::is_letter(char_code) || asm_tok_pkg::is_digit(char_code)))
                begin
                    close_v        = 1'b1;
                    close_tok.kind = (mode_reg == asm_tok_pkg::MODE_MNEM)
                                   ? asm_tok_pkg::KIND_MNEM : asm_tok_pkg::KIND_FLAG;
                    between        = 1'b1;
                end
            end
            asm_tok_pkg::MODE_NUM:
            begin
                if (!asm_tok_pkg::is_digit(char_code))
                begin
                    close_v        = 1'b1;
                    close_tok.kind = asm_tok_pkg::KIND_NUM;
                    between        = 1'b1;
                end
            end
            asm_tok_pkg::MODE_COMMENT:
            begin
                if (char_code == asm_tok_pkg::CH_LF)
                begin
                    mode_next = asm_tok_pkg::MODE_IDLE;
                end
                else if (char_code == asm_tok_pkg::CH_NUL)
                begin
                    between = 1'b1;
                end
            end
            default:
            begin
                between = 1'b1;
            end
        endcase

        // byte handled as if between tokens
        if (between)
        begin
            mode_next = asm_tok_pkg::MODE_IDLE;
            if (char_code == asm_tok_pkg::CH_NUL)
            begin
                second_v        = 1'b1;
                second_tok.kind = asm_tok_pkg::KIND_END;
                pos_next        = '0;
            end
            else if (asm_tok_pkg::is_separator(char_code))
            begin
                mode_next = asm_tok_pkg::MODE_IDLE;
            end
            else if (asm_tok_pkg::is_letter(char_code))
            begin
                mode_next  = asm_tok_pkg::MODE_MNEM;
                begin_next = pos_reg;
            end
            else if (char_code == asm_tok_pkg::CH_DOT)
            begin
                mode_next  = asm_tok_pkg::MODE_FLAG;
                begin_next = asm_tok_pkg::pos_inc(pos_reg);
            end
            else if (asm_tok_pkg::is_digit(char_code))
            begin
                mode_next  = asm_tok_pkg::MODE_NUM;
                begin_next = pos_reg;
            end
            else if (char_code == asm_tok_pkg::CH_SEMI)
            begin
                mode_next = asm_tok_pkg::MODE_COMMENT;
            end
            else
            begin
                second_v        = 1'b1;
                second_tok.kind = asm_tok_pkg::KIND_UNKNOWN;
            end
        end

        // order the results and mark the final one
        n_res       = {1'b0, close_v} + {1'b0, second_v};
        entry0      = close_v ? close_tok : second_tok;
        entry1      = second_tok;
        entry0.last = (n_res == 2'd1);
        entry1.last = 1'b1;
    end

    // queue pointer and count arithmetic
    assign wr_ptr_plus1 = wr_ptr_reg + asm_tok_pkg::QUEUE_IDX_BITS'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + asm_tok_pkg::QUEUE_IDX_BITS'(n_res);
            count_next  = count_next + asm_tok_pkg::QUEUE_CNT_BITS'(n_res);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + asm_tok_pkg::QUEUE_IDX_BITS'(1);
            count_next  = count_next - asm_tok_pkg::QUEUE_CNT_BITS'(1);
        end
    end

    // control and lexer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= asm_tok_pkg::MODE_IDLE;
            begin_reg  <= '0;
            pos_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg  <= mode_next;
                begin_reg <= begin_next;
                pos_reg   <= pos_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (accept && (n_res != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= entry0;
        end
        if (accept && (n_res == 2'd2))
        begin
            queue_reg[wr_ptr_plus1] <= entry1;
        end
    end

    // output fields from the queue head
    assign token_kind   = queue_reg[rd_ptr_reg].kind;
    assign token_start  = queue_reg[rd_ptr_reg].start;
    assign token_length = queue_reg[rd_ptr_reg].length;
    assign last_of_run  = queue_reg[rd_ptr_reg].last;

endmodule
